FILE: hdl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int VALUE_BITS = 32;
  // Decimal digits needed for the largest magnitude: floor(bits*log10(2)) + 1
  localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] MINUS_CODE = 8'd45;
  localparam logic [7:0] ZERO_CODE  = 8'd48;

  typedef logic [3:0] bcd_digit_t;

  typedef struct packed {
    logic clear;      // zero the digit
    logic shift_bin;  // adjust and shift one binary bit in
    logic shift_dig;  // take the lower neighbor's digit
  } cell_ctl_t;

endpackage

FILE: hdl/i2a_cell.sv
// ----------------------------------------------------------------------------
// i2a_cell
// One decimal digit of the shift-and-add-3 chain; also shifts digits upward.
// ----------------------------------------------------------------------------
module i2a_cell (
  input  logic                clk,
  input  i2a_pkg::cell_ctl_t  ctl_i,
  input  logic                cin_i,
  input  i2a_pkg::bcd_digit_t din_i,
  output logic                cout_o,
  output i2a_pkg::bcd_digit_t digit_o
);
  import i2a_pkg::*;

  bcd_digit_t digit_r;
  bcd_digit_t digit_nxt;
  bcd_digit_t adj;

  // add 3 when the digit would reach ten or more after doubling
  assign adj     = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign cout_o  = adj[3];
  assign digit_o = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctl_i.clear) begin
      digit_nxt = '0;
    end else if (ctl_i.shift_bin) begin
      digit_nxt = {adj[2:0], cin_i};
    end else if (ctl_i.shift_dig) begin
      digit_nxt = din_i;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

FILE: hdl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed integer to decimal ASCII text, one character per strobe.
// ----------------------------------------------------------------------------
//  channel  | ports                              | handshake
//  ---------+------------------------------------+---------------------------
//  input    | in_value[31:0] (signed)            | start high, busy low
//  result   | out_char_code[7:0], out_last_char  | out_valid, one cycle each
//
//  One number at a time. After the transfer, the magnitude shifts through
//  the digit cells serially, one step per bit, a '-' goes out for negative
//  values, leading zero digits are dropped at one per cycle, then one
//  character leaves per cycle. A number passes through the transfer, the
//  serial shift, the '-' for a negative value, the dropping of leading
//  zeros, a step to find the first digit and the sending of the digits;
//  the next number is taken only once the last character is out.
//  Reset (rst_n low, synchronous) returns to idle; the receiver cannot
//  stall, so out_valid is never held off.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [i2a_pkg::VALUE_BITS-1:0] in_value,
  output logic                                 out_valid,
  output logic [7:0]                           out_char_code,
  output logic                                 out_last_char
);
  import i2a_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SIGN = 3'd2;
  localparam logic [2:0] ST_SKIP = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]  dig_cnt_r, dig_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  cell_ctl_t             ctl;
  logic                  carry [NUM_DIGITS];
  bcd_digit_t            dig   [NUM_DIGITS];
  bcd_digit_t            top_digit;
  logic                  accept;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign top_digit = dig[NUM_DIGITS-1];

  // Row of digit cells: binary bits enter at the bottom, digits leave at the top.
  assign carry[0] = mag_r[VALUE_BITS-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    bcd_digit_t din;
    if (i == 0) begin : g_bottom
      assign din = '0;
    end else begin : g_upper
      assign din = dig[i-1];
    end
    if (i < NUM_DIGITS - 1) begin : g_link
      i2a_cell u_cell (
        .clk     (clk),
        .ctl_i   (ctl),
        .cin_i   (carry[i]),
        .din_i   (din),
        .cout_o  (carry[i+1]),
        .digit_o (dig[i])
      );
    end else begin : g_top
      // the top digit never overflows for any magnitude of VALUE_BITS bits
      i2a_cell u_cell (
        .clk     (clk),
        .ctl_i   (ctl),
        .cin_i   (carry[i]),
        .din_i   (din),
        .cout_o  (),
        .digit_o (dig[i])
      );
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // take the magnitude in an unsigned word so the most negative value fits
          neg_nxt     = in_value[VALUE_BITS-1];
          mag_nxt     = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
          bit_cnt_nxt = BIT_CNT_W'(VALUE_BITS);
          dig_cnt_nxt = DIG_CNT_W'(NUM_DIGITS);
          ctl.clear   = 1'b1;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.shift_bin = 1'b1;
        mag_nxt       = mag_r << 1;
        bit_cnt_nxt   = bit_cnt_r - 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(1)) begin
          state_nxt = neg_r ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = MINUS_CODE;
        out_last_nxt  = 1'b0;
        state_nxt     = ST_SKIP;
      end
      ST_SKIP: begin
        // drop leading zeros, but keep at least one digit for zero
        if ((top_digit == '0) && (dig_cnt_r != DIG_CNT_W'(1))) begin
          ctl.shift_dig = 1'b1;
          dig_cnt_nxt   = dig_cnt_r - 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = ZERO_CODE + {4'b0, top_digit};
        out_last_nxt  = (dig_cnt_r == DIG_CNT_W'(1));
        ctl.shift_dig = 1'b1;
        dig_cnt_nxt   = dig_cnt_r - 1'b1;
        if (dig_cnt_r == DIG_CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

endmodule
